/* hw/rtl/eci_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eci_pkg: shared types and constants of the easing curve interpolator
// fixed widths, curve codes, back and bounce constants in Q16
// ---------------------------------------------------------------------------
package eci_pkg;

  localparam int VALUE_BITS = 32;
  localparam int TIME_BITS  = 16;
  localparam int FRAC_BITS  = 16;
  localparam int DIV_STAGES = FRAC_BITS / 2;
  localparam int W          = 40;  // working width of the curve datapath

  localparam logic signed [W-1:0] Q_ONE   = W'(65536);
  localparam logic signed [W-1:0] Q_HALF  = W'(32768);
  localparam logic signed [W-1:0] Q_TWO   = W'(131072);
  localparam logic signed [W-1:0] BK_C1   = W'(111515);
  localparam logic signed [W-1:0] BK_C2   = W'(170060);
  localparam logic signed [W-1:0] BK_C3   = W'(177051);
  localparam logic signed [W-1:0] BK_C2P1 = W'(235596);

  // bounce: thresholds on 11*u, offsets and bases
  localparam logic signed [W-1:0] BN_TH1 = W'(262144);
  localparam logic signed [W-1:0] BN_TH2 = W'(524288);
  localparam logic signed [W-1:0] BN_TH3 = W'(655360);
  localparam logic signed [W-1:0] BN_OF2 = W'(393216);
  localparam logic signed [W-1:0] BN_OF3 = W'(589824);
  localparam logic signed [W-1:0] BN_OF4 = W'(688128);
  localparam logic signed [W-1:0] BN_BS2 = W'(49152);
  localparam logic signed [W-1:0] BN_BS3 = W'(61440);
  localparam logic signed [W-1:0] BN_BS4 = W'(64512);

  typedef enum logic [3:0] {
    ACT_QUAD_IN      = 4'd0,
    ACT_QUAD_OUT     = 4'd1,
    ACT_QUAD_INOUT   = 4'd2,
    ACT_BACK_IN      = 4'd3,
    ACT_BACK_OUT     = 4'd4,
    ACT_BACK_INOUT   = 4'd5,
    ACT_BOUNCE_OUT   = 4'd6,
    ACT_BOUNCE_IN    = 4'd7,
    ACT_BOUNCE_INOUT = 4'd8
  } act_t;

  // data that rides alongside every stage
  typedef struct packed {
    logic [3:0]                  act;
    logic signed [VALUE_BITS-1:0] st;
    logic signed [VALUE_BITS:0]   mv;
  } side_t;

endpackage

/* hw/rtl/easing_curve_interpolator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// easing_curve_interpolator: fixed-point easing curves
// divides elapsed by duration, shapes t with one of nine curves and blends
// start and end values, saturating the result
// ---------------------------------------------------------------------------
// throughput: one transfer per cycle while the result side does not stall; a
//   16-stage pipeline (input register, 8 divider stages of two quotient bits
//   each, 5 curve stages, multiply and sum stages)
// a stall on the result side freezes the whole pipeline, nothing is dropped
// reset: synchronous, active low, clears the valid bits only
module easing_curve_interpolator
  import eci_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // action[3:0], start_value[35:4], end_value[67:36],
                                  // elapsed[83:68], duration[99:84], zero fill
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata, // eased_value[31:0]
  output logic         out_tuser  // saturated
);

  localparam int NST = DIV_STAGES + 7;  // stages before the output register

  // global advance: the pipeline moves when the output slot is free or taken
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  logic  vld_r [NST];
  side_t side_r[NST];

  // divider registers, stage 0 is the input register
  logic [TIME_BITS-1:0] rem_r  [DIV_STAGES+1];
  logic [TIME_BITS-1:0] du_r   [DIV_STAGES+1];
  logic [FRAC_BITS-1:0] q_r    [DIV_STAGES+1];
  logic                 full_r [DIV_STAGES+1];
  logic [TIME_BITS-1:0] rem_nxt[DIV_STAGES+1];
  logic [FRAC_BITS-1:0] q_nxt  [DIV_STAGES+1];

  // input field unpacking
  logic [3:0]                   in_act;
  logic signed [VALUE_BITS-1:0] in_st, in_en;
  logic [TIME_BITS-1:0]         in_el, in_du;
  assign in_act = in_tdata[3:0];
  assign in_st  = in_tdata[35:4];
  assign in_en  = in_tdata[67:36];
  assign in_el  = in_tdata[83:68];
  assign in_du  = in_tdata[99:84];

  // restoring division, two quotient bits per stage
  always_comb begin
    logic [TIME_BITS:0] r2;
    logic [TIME_BITS-1:0] r;
    logic [FRAC_BITS-1:0] q;
    for (int k = 0; k <= DIV_STAGES; k++) begin
      rem_nxt[k] = '0;
      q_nxt[k]   = '0;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      r = rem_r[k-1];
      q = q_r[k-1];
      for (int j = 0; j < 2; j++) begin
        r2 = {r, 1'b0};
        if (r2 >= {1'b0, du_r[k-1]}) begin
          r  = TIME_BITS'(r2 - {1'b0, du_r[k-1]});
          q  = {q[FRAC_BITS-2:0], 1'b1};
        end else begin
          r  = r2[TIME_BITS-1:0];
          q  = {q[FRAC_BITS-2:0], 1'b0};
        end
      end
      rem_nxt[k] = r;
      q_nxt[k]   = q;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0]  <= in_el;
      du_r[0]   <= in_du;
      q_r[0]    <= '0;
      full_r[0] <= (in_du == '0) || (in_el >= in_du);
      for (int k = 1; k <= DIV_STAGES; k++) begin
        rem_r[k]  <= rem_nxt[k];
        q_r[k]    <= q_nxt[k];
        du_r[k]   <= du_r[k-1];
        full_r[k] <= full_r[k-1];
      end
    end
  end

  // side data and valid bits
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].act <= in_act;
      side_r[0].st  <= in_st;
      side_r[0].mv  <= (VALUE_BITS+1)'(in_en) - (VALUE_BITS+1)'(in_st);
      for (int i = 1; i < NST; i++) side_r[i] <= side_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < NST; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  localparam int SA = DIV_STAGES + 1;  // curve operand stage index
  localparam int SB = SA + 1;          // square stage
  localparam int SC = SA + 2;          // second product stage
  localparam int SD = SA + 3;          // back constant products
  localparam int SE = SA + 4;          // curve value
  localparam int SF = SA + 5;          // blend products

  // ---- stage A: normalised t, curve operand x, bounce segment ----
  logic signed [W-1:0] ta_nxt, xa_nxt, basea_nxt;
  logic                halfa_nxt;
  logic signed [W-1:0] ta_r, xa_r, basea_r;
  logic                halfa_r;

  always_comb begin
    logic signed [W-1:0] t, u, e;
    t = full_r[DIV_STAGES] ? Q_ONE : W'($signed({1'b0, q_r[DIV_STAGES]}));
    halfa_nxt = (t < Q_HALF);
    case (side_r[DIV_STAGES].act)
      ACT_BOUNCE_OUT: u = t;
      ACT_BOUNCE_IN:  u = Q_ONE - t;
      default:        u = halfa_nxt ? (Q_ONE - (t <<< 1)) : ((t <<< 1) - Q_ONE);
    endcase
    e = (u <<< 3) + (u <<< 1) + u;
    if (e < BN_TH1) begin
      basea_nxt = '0;     u = e;
    end else if (e < BN_TH2) begin
      basea_nxt = BN_BS2; u = e - BN_OF2;
    end else if (e < BN_TH3) begin
      basea_nxt = BN_BS3; u = e - BN_OF3;
    end else begin
      basea_nxt = BN_BS4; u = e - BN_OF4;
    end
    case (side_r[DIV_STAGES].act) inside
      ACT_QUAD_IN, ACT_BACK_IN: xa_nxt = t;
      ACT_QUAD_OUT:             xa_nxt = Q_ONE - t;
      ACT_QUAD_INOUT:           xa_nxt = halfa_nxt ? t : (Q_TWO - (t <<< 1));
      ACT_BACK_OUT:             xa_nxt = t - Q_ONE;
      ACT_BACK_INOUT:           xa_nxt = halfa_nxt ? (t <<< 1) : ((t <<< 1) - Q_TWO);
      ACT_BOUNCE_OUT, ACT_BOUNCE_IN, ACT_BOUNCE_INOUT: xa_nxt = u;
      default:                  xa_nxt = t;
    endcase
    ta_nxt = t;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ta_r    <= ta_nxt;
      xa_r    <= xa_nxt;
      basea_r <= basea_nxt;
      halfa_r <= halfa_nxt;
    end
  end

  // ---- stage B: square of x, back in-out slope term ----
  // curve operands stay within 20 signed bits
  logic signed [W-1:0] sqb_r, bb_r, tb_r, xb_r, baseb_r;
  logic                halfb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sqb_r   <= W'($signed(xa_r[19:0])) * W'($signed(xa_r[19:0]));
      bb_r    <= ((BK_C2P1 * W'($signed(xa_r[19:0]))) >>> 16) +
                 (halfa_r ? -BK_C2 : BK_C2);
      tb_r    <= ta_r;
      xb_r    <= xa_r;
      baseb_r <= basea_r;
      halfb_r <= halfa_r;
    end
  end

  // ---- stage C: simple curves finish, cube or back in-out product ----
  logic signed [W-1:0] x2c_r, mcc_r, csc_r;
  logic                halfc_r;
  logic signed [W-1:0] x2c_nxt, mcc_nxt, csc_nxt;

  always_comb begin
    logic signed [W-1:0] x2, bo, m;
    x2 = sqb_r >>> 16;
    bo = (sqb_r >>> 20) + baseb_r;
    case (side_r[SB].act)
      ACT_QUAD_IN:      csc_nxt = x2;
      ACT_QUAD_OUT:     csc_nxt = Q_ONE - x2;
      ACT_QUAD_INOUT:   csc_nxt = halfb_r ? (sqb_r >>> 15) : (Q_ONE - (sqb_r >>> 17));
      ACT_BOUNCE_OUT:   csc_nxt = bo;
      ACT_BOUNCE_IN:    csc_nxt = Q_ONE - bo;
      ACT_BOUNCE_INOUT: csc_nxt = halfb_r ? ((Q_ONE - bo) >>> 1) : ((Q_ONE + bo) >>> 1);
      default:          csc_nxt = tb_r;
    endcase
    // back curves only: square and second factor fit in 24 signed bits
    m = (side_r[SB].act == ACT_BACK_INOUT) ? bb_r : xb_r;
    mcc_nxt = W'($signed(x2[23:0])) * W'($signed(m[23:0]));
    x2c_nxt = x2;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x2c_r   <= x2c_nxt;
      mcc_r   <= mcc_nxt;
      csc_r   <= csc_nxt;
      halfc_r <= halfb_r;
    end
  end

  // ---- stage D: back constant products ----
  logic signed [W-1:0] pad_r, pbd_r, cd_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      pad_r <= BK_C3 * W'($signed(mcc_r[35:16]));
      pbd_r <= BK_C1 * W'($signed(x2c_r[19:0]));
      if (side_r[SC].act == ACT_BACK_INOUT) begin
        cd_r <= (mcc_r >>> 17) + (halfc_r ? W'(0) : Q_ONE);
      end else begin
        cd_r <= csc_r;
      end
    end
  end

  // ---- stage E: curve value c ----
  logic signed [19:0] ce_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      case (side_r[SD].act)
        ACT_BACK_IN:  ce_r <= 20'((pad_r - pbd_r) >>> 16);
        ACT_BACK_OUT: ce_r <= 20'(Q_ONE + ((pad_r + pbd_r) >>> 16));
        default:      ce_r <= 20'(cd_r);
      endcase
    end
  end

  // ---- stage F: (end - start) split in high and low halves times c ----
  logic signed [W-1:0] phf_r, plf_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      phf_r <= W'(side_r[SE].mv >>> 16) * W'(ce_r);
      plf_r <= W'($signed({1'b0, side_r[SE].mv[15:0]})) * W'(ce_r);
    end
  end

  // ---- output: sum and saturation ----
  localparam logic signed [W-1:0] VMAX = W'({1'b0, {(VALUE_BITS-1){1'b1}}});
  localparam logic signed [W-1:0] VMIN = -VMAX - W'(1);

  logic signed [W-1:0] sum;
  logic [31:0]         val_nxt;
  logic                sat_nxt;
  logic                out_tvalid_r;
  logic [31:0]         out_tdata_r;
  logic                out_tuser_r;

  always_comb begin
    sum = W'(side_r[SF].st) + phf_r + (plf_r >>> 16);
    if (sum > VMAX) begin
      val_nxt = VMAX[31:0]; sat_nxt = 1'b1;
    end else if (sum < VMIN) begin
      val_nxt = VMIN[31:0]; sat_nxt = 1'b1;
    end else begin
      val_nxt = sum[31:0];  sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      out_tvalid_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tdata_r <= val_nxt;
      out_tuser_r <= sat_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // ---- checks ----
  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata == 32'h7fffffff || out_tdata == 32'h80000000))
    else $error("saturated result not at a range limit");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted transfer not captured");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

/* test/eci_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// eci_checker: result predictor and scoreboard for the easing interpolator
// predicts each eased value from the input transfers and compares it with
// the result transfers in order
// ---------------------------------------------------------------------------
module eci_checker
  import eci_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [103:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata,
  input  logic         out_tuser,
  output int           err_count,
  output int           pending
);

  localparam longint ONE = 65536;
  localparam longint C1  = 111515;
  localparam longint C2  = 170060;
  localparam longint C3  = 177051;

  typedef struct {
    logic [31:0] eased;
    logic        sat;
  } eased_t;

  eased_t expected_q[$];

  // floor division by 2^s
  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint bounce_shape(longint t);
    longint e, w, base;
    e = 11 * t;
    if (e < 4 * ONE) begin
      w = e; base = 0;
    end else if (e < 8 * ONE) begin
      w = e - 6 * ONE; base = 49152;
    end else if (e < 10 * ONE) begin
      w = e - 9 * ONE; base = 61440;
    end else begin
      w = e - 688128; base = 64512;
    end
    return floor_shr(w * w, 20) + base;
  endfunction

  function automatic longint curve_factor(logic [3:0] act, longint t);
    longint a, a2, b, v, v2, v3, t2, t3, s;
    case (act)
      ACT_QUAD_IN: return floor_shr(t * t, 16);
      ACT_QUAD_OUT: begin
        s = ONE - t;
        return ONE - floor_shr(s * s, 16);
      end
      ACT_QUAD_INOUT: begin
        if (t < ONE / 2) return floor_shr(2 * t * t, 16);
        s = 2 * ONE - 2 * t;
        return ONE - floor_shr(s * s, 17);
      end
      ACT_BACK_IN: begin
        t2 = floor_shr(t * t, 16);
        t3 = floor_shr(t2 * t, 16);
        return floor_shr(C3 * t3 - C1 * t2, 16);
      end
      ACT_BACK_OUT: begin
        v = t - ONE;
        v2 = floor_shr(v * v, 16);
        v3 = floor_shr(v2 * v, 16);
        return ONE + floor_shr(C3 * v3 + C1 * v2, 16);
      end
      ACT_BACK_INOUT: begin
        if (t < ONE / 2) begin
          a = 2 * t;
          a2 = floor_shr(a * a, 16);
          b = floor_shr((C2 + ONE) * a, 16) - C2;
          return floor_shr(a2 * b, 17);
        end
        a = 2 * t - 2 * ONE;
        a2 = floor_shr(a * a, 16);
        b = floor_shr((C2 + ONE) * a, 16) + C2;
        return floor_shr(a2 * b, 17) + ONE;
      end
      ACT_BOUNCE_OUT: return bounce_shape(t);
      ACT_BOUNCE_IN: return ONE - bounce_shape(ONE - t);
      ACT_BOUNCE_INOUT: begin
        if (t < ONE / 2) return floor_shr(ONE - bounce_shape(ONE - 2 * t), 1);
        return floor_shr(ONE + bounce_shape(2 * t - ONE), 1);
      end
      default: return t;  // unused codes fall back to linear
    endcase
  endfunction

  function automatic eased_t predict_eased(logic [103:0] d);
    eased_t r;
    longint st, en, el, du, t, c, mv, hi, lo, sum;
    st = longint'($signed(d[35:4]));
    en = longint'($signed(d[67:36]));
    el = longint'(d[83:68]);
    du = longint'(d[99:84]);
    if (du == 0 || el >= du) t = ONE;
    else t = (el << 16) / du;
    c = curve_factor(d[3:0], t);
    mv = en - st;
    hi = floor_shr(mv, 16);
    lo = mv - hi * ONE;
    sum = st + hi * c + floor_shr(lo * c, 16);
    r.sat = 1'b0;
    if (sum > 64'sd2147483647) begin
      sum = 64'sd2147483647; r.sat = 1'b1;
    end
    if (sum < -64'sd2147483648) begin
      sum = -64'sd2147483648; r.sat = 1'b1;
    end
    r.eased = sum[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    eased_t e;
    if (!rst_n) begin
      err_count <= 0;
      pending   <= 0;
    end else begin
      if (in_tvalid && in_tready) expected_q.push_back(predict_eased(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result eased %h sat %b", $time, out_tdata, out_tuser);
          err_count <= err_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.eased !== out_tdata || e.sat !== out_tuser) begin
            $display("%0t: mismatch expected eased %h sat %b, actual eased %h sat %b",
                     $time, e.eased, e.sat, out_tdata, out_tuser);
            err_count <= err_count + 1;
          end
        end
      end
      pending <= expected_q.size();
    end
  end

endmodule

/* test/tb_easing_curve_interpolator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_easing_curve_interpolator: stream test of the easing interpolator
// directed corner items then random curves, values and times, with random
// gaps on both sides and one long result-side hold-off
// ---------------------------------------------------------------------------
module tb_easing_curve_interpolator
  import eci_pkg::*;
();

  localparam int RANDOM_ITEMS = 1000;
  localparam int IDLE_LIMIT   = 5000;   // cycles with no transfer at all
  localparam int DRAIN_CYCLES = 40;     // pipeline is 16 deep

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         out_tuser;
  int           err_count;
  int           pending;

  // sink pacing: 0 random gaps, 1 no gaps, 2 long hold-off
  int           sink_mode = 0;
  int           idle_cycles = 0;

  always #1 clk = ~clk;

  easing_curve_interpolator u_dut (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  eci_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .err_count, .pending
  );

  // result side pacing, owned by its own process
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (sink_mode == 2) begin
      out_tready <= 1'b0;
    end else if (sink_mode == 1) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 19);
    end
  end

  // long receiver hold-off so the pipeline fills and backs up the input
  initial begin
    wait (u_checker.pending > 0);
    repeat (200) @(posedge clk);
    sink_mode = 2;
    repeat (150) @(posedge clk);
    sink_mode = 0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || sink_mode == 2)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // one input transfer; gaps drawn at random unless told otherwise
  task automatic send_item(input logic [3:0] act, input logic [31:0] st,
                           input logic [31:0] en, input logic [15:0] el,
                           input logic [15:0] du, input bit gaps);
    while (gaps && $urandom_range(99) < 19) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, du, el, en, st, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [3:0]  act;
    logic [15:0] du, el;
    bit          gaps;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every curve at time zero and at the midpoint
    for (int a = 0; a < 9; a++) begin
      send_item(4'(a), 32'h00000000, 32'h00010000, 16'd0, 16'd100, 1'b0);
      send_item(4'(a), 32'h80000000, 32'h7fffffff, 16'd50, 16'd100, 1'b0);
    end
    // zero duration, elapsed past duration, unused codes, saturation
    send_item(ACT_QUAD_IN, 32'h00010000, 32'h00050000, 16'd5, 16'd0, 1'b0);
    send_item(ACT_QUAD_OUT, 32'h00010000, 32'h00050000, 16'hffff, 16'd3, 1'b0);
    send_item(4'd9, 32'h12345678, 32'hedcba987, 16'd1, 16'd2, 1'b0);
    send_item(4'd15, 32'hffffffff, 32'h00000000, 16'hfffe, 16'hffff, 1'b0);
    send_item(ACT_BACK_OUT, 32'h7fff0000, 32'h80000000, 16'd10, 16'd30, 1'b0);
    send_item(ACT_BACK_IN, 32'h80000000, 32'h7fffffff, 16'd20, 16'd100, 1'b0);
    send_item(ACT_BACK_INOUT, 32'h7fffffff, 32'h80000000, 16'd85, 16'd100, 1'b0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) sink_mode = 1;
      if (i == 450) sink_mode = 0;
      gaps = !(i >= 300 && i < 450);
      act = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      case ($urandom_range(7))
        0: du = 16'd0;
        1: du = 16'($urandom);
        default: du = 16'($urandom_range(1000, 1));
      endcase
      case ($urandom_range(7))
        0: el = 16'($urandom);
        1: el = du;
        default: el = (du == 0) ? 16'($urandom) : 16'($urandom_range(du - 1));
      endcase
      send_item(act, pick_value(), pick_value(), el, du, gaps);
    end
    in_tvalid <= 1'b0;

    while (pending > 0 || sink_mode == 2) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* easing_curve_interpolator.f */
hw/rtl/eci_pkg.sv
hw/rtl/easing_curve_interpolator.sv
test/eci_checker.sv
test/tb_easing_curve_interpolator.sv
